### hdl/hamming_ratio_test_matcher_assert.svh
// assertion macros used by the checker file
`ifndef HAMMING_RATIO_TEST_MATCHER_ASSERT_SVH
`define HAMMING_RATIO_TEST_MATCHER_ASSERT_SVH

// same-cycle implication, quiet during reset
`define HRTM_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("hrtm assertion failed");

// next-cycle implication, quiet during reset
`define HRTM_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("hrtm assertion failed");

`endif

### hdl/hrtm_pkg.sv
package hrtm_pkg;

    localparam int DESC_BITS = 256;
    localparam int WORD_BITS = 64;
    localparam int NUM_WORDS = DESC_BITS / WORD_BITS;
    localparam int WI_W      = 2;
    localparam int DIST_W    = 9;
    localparam int IDX_W     = 12;
    localparam int POP_W     = 7;
    localparam int REG_W     = 9;
    localparam int ADDR_W    = 3;

    localparam logic [WI_W-1:0]   LAST_WORD = WI_W'(NUM_WORDS - 1);
    localparam logic [DIST_W-1:0] DIST_NONE = DIST_W'(DESC_BITS);

    // operation codes
    localparam logic [1:0] OP_LOAD   = 2'd0;
    localparam logic [1:0] OP_CAND   = 2'd1;
    localparam logic [1:0] OP_FINISH = 2'd2;

    // reject reasons
    localparam logic [1:0] REASON_ACCEPT  = 2'd0;
    localparam logic [1:0] REASON_THRESH  = 2'd1;
    localparam logic [1:0] REASON_RATIO   = 2'd2;
    localparam logic [1:0] REASON_NO_CAND = 2'd3;

    // register indexes
    localparam logic REG_THRESHOLD = 1'b0;
    localparam logic REG_RATIO     = 1'b1;

    localparam logic [REG_W-1:0] THRESHOLD_RESET = 9'd50;
    localparam logic [REG_W-1:0] RATIO_RESET     = 9'd154;

    typedef struct packed {
        logic [DIST_W-1:0] best;
        logic [DIST_W-1:0] second;
        logic [IDX_W-1:0]  best_idx;
        logic              have;
    } track_t;

    typedef struct packed {
        logic              match_found;
        logic [IDX_W-1:0]  best_index;
        logic [DIST_W-1:0] best_distance;
        logic [DIST_W-1:0] second_distance;
        logic [1:0]        reject_reason;
    } result_t;

endpackage

### hdl/hrtm_popcount.sv
module hrtm_popcount (
    input  logic [hrtm_pkg::WORD_BITS-1:0] word,
    output logic [hrtm_pkg::POP_W-1:0]     count
);
    import hrtm_pkg::*;

    logic [1:0] l1 [32];
    logic [2:0] l2 [16];
    logic [3:0] l3 [8];
    logic [4:0] l4 [4];
    logic [5:0] l5 [2];

    // balanced adder tree, one level per loop
    always_comb
    begin
        for (int i = 0; i < 32; i++)
        begin
            l1[i] = {1'b0, word[2*i]} + {1'b0, word[2*i+1]};
        end
        for (int i = 0; i < 16; i++)
        begin
            l2[i] = {1'b0, l1[2*i]} + {1'b0, l1[2*i+1]};
        end
        for (int i = 0; i < 8; i++)
        begin
            l3[i] = {1'b0, l2[2*i]} + {1'b0, l2[2*i+1]};
        end
        for (int i = 0; i < 4; i++)
        begin
            l4[i] = {1'b0, l3[2*i]} + {1'b0, l3[2*i+1]};
        end
        for (int i = 0; i < 2; i++)
        begin
            l5[i] = {1'b0, l4[2*i]} + {1'b0, l4[2*i+1]};
        end
        count = {1'b0, l5[0]} + {1'b0, l5[1]};
    end

endmodule

### hdl/hrtm_decide.sv
module hrtm_decide (
    input  hrtm_pkg::track_t              track,
    input  logic [hrtm_pkg::REG_W-1:0]    threshold,
    input  logic [hrtm_pkg::REG_W-1:0]    ratio,
    output hrtm_pkg::result_t             result
);
    import hrtm_pkg::*;

    logic [2*REG_W-1:0] ratio_prod;
    logic [2*REG_W-1:0] best_scaled;
    logic [1:0]         reason;

    // ratio * second < 256 * best
    assign ratio_prod  = {{REG_W{1'b0}}, ratio} * {{(2*REG_W-DIST_W){1'b0}}, track.second};
    assign best_scaled = {{(2*REG_W-DIST_W-8){1'b0}}, track.best, 8'd0};

    always_comb
    begin
        if (!track.have)
        begin
            reason = REASON_NO_CAND;
        end
        else if (threshold < track.best)
        begin
            reason = REASON_THRESH;
        end
        else if (ratio_prod < best_scaled)
        begin
            reason = REASON_RATIO;
        end
        else
        begin
            reason = REASON_ACCEPT;
        end
        result.match_found     = (reason == REASON_ACCEPT);
        result.best_index      = track.best_idx;
        result.best_distance   = track.best;
        result.second_distance = track.second;
        result.reject_reason   = reason;
    end

endmodule

### hdl/hamming_ratio_test_matcher.sv
// a finish word's result is registered: it passes the input register, then the result register
// throughput: one word per cycle while no finish word waits; load and candidate words never stall
// a finish word waits in the work stage only while the result register is full
// reset: asynchronous active low, clears the search state and the handshakes,
// threshold returns to 50 and ratio to 154; the query store is not cleared
module hamming_ratio_test_matcher (
    input  logic                               clk,
    input  logic                               rst_n,
    // input channel
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic [1:0]                         operation,
    input  logic [hrtm_pkg::WI_W-1:0]          word_index,
    input  logic [hrtm_pkg::WORD_BITS-1:0]     descriptor_word,
    input  logic [hrtm_pkg::IDX_W-1:0]         candidate_index,
    input  logic                               candidate_skip,
    // result channel
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic                               match_found,
    output logic [hrtm_pkg::IDX_W-1:0]         best_index,
    output logic [hrtm_pkg::DIST_W-1:0]        best_distance,
    output logic [hrtm_pkg::DIST_W-1:0]        second_distance,
    output logic [1:0]                         reject_reason,
    // configuration port
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [hrtm_pkg::ADDR_W-1:0]        paddr,
    input  logic [31:0]                        pwdata,
    output logic [31:0]                        prdata,
    output logic                               pready
);
    import hrtm_pkg::*;

    // ---------------------------------------------------------------
    // configuration registers
    // ---------------------------------------------------------------
    logic [REG_W-1:0] threshold_reg;
    logic [REG_W-1:0] ratio_reg;
    logic             cfg_write;
    logic             cfg_sel;

    assign pready    = 1'b1;
    assign cfg_sel   = paddr[2];
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg <= THRESHOLD_RESET;
            ratio_reg     <= RATIO_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_sel)
                REG_THRESHOLD: threshold_reg <= pwdata[REG_W-1:0];
                REG_RATIO:     ratio_reg     <= pwdata[REG_W-1:0];
                default:       threshold_reg <= threshold_reg;
            endcase
        end
    end

    // read back, zero extended
    always_comb
    begin
        case (cfg_sel)
            REG_THRESHOLD: prdata = {{(32-REG_W){1'b0}}, threshold_reg};
            REG_RATIO:     prdata = {{(32-REG_W){1'b0}}, ratio_reg};
            default:       prdata = '0;
        endcase
    end

    // ---------------------------------------------------------------
    // input register: holds the accepted word for the work stage
    // ---------------------------------------------------------------
    logic                  s1_valid_reg;
    logic                  s1_valid_next;
    logic [1:0]            s1_op_reg;
    logic [WI_W-1:0]       s1_wi_reg;
    logic [WORD_BITS-1:0]  s1_word_reg;
    logic [IDX_W-1:0]      s1_cidx_reg;
    logic                  s1_skip_reg;
    logic                  s1_advance;
    logic                  in_accept;
    logic                  out_valid_reg;
    logic                  out_valid_next;

    // only a finish word needs room downstream
    assign s1_advance = s1_valid_reg &&
                        ((s1_op_reg != OP_FINISH) || !out_valid_reg || out_ready);
    assign in_ready   = !s1_valid_reg || s1_advance;
    assign in_accept  = in_valid && in_ready;

    always_comb
    begin
        if (in_accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_advance)
        begin
            s1_valid_next = 1'b0;
        end
        else
        begin
            s1_valid_next = s1_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    // payload, no reset needed
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_op_reg   <= operation;
            s1_wi_reg   <= word_index;
            s1_word_reg <= descriptor_word;
            s1_cidx_reg <= candidate_index;
            s1_skip_reg <= candidate_skip;
        end
    end

    // ---------------------------------------------------------------
    // query store: four words, undefined until loaded
    // ---------------------------------------------------------------
    logic [WORD_BITS-1:0] query_mem [NUM_WORDS];
    logic                 s1_do_load;
    logic                 s1_do_cand;
    logic                 s1_do_finish;

    assign s1_do_load   = s1_advance && (s1_op_reg == OP_LOAD);
    assign s1_do_cand   = s1_advance && (s1_op_reg == OP_CAND);
    assign s1_do_finish = s1_advance && (s1_op_reg == OP_FINISH);

    always_ff @(posedge clk)
    begin
        if (s1_do_load)
        begin
            query_mem[s1_wi_reg] <= s1_word_reg;
        end
    end

    // ---------------------------------------------------------------
    // distance of this word and running sum, saturating at full length
    // ---------------------------------------------------------------
    logic [POP_W-1:0]  word_dist;
    logic [DIST_W:0]   acc_sum;
    logic [DIST_W-1:0] acc_sat;
    logic [DIST_W-1:0] running_reg;
    logic [DIST_W-1:0] running_next;

    hrtm_popcount u_popcount (
        .word  (s1_word_reg ^ query_mem[s1_wi_reg]),
        .count (word_dist)
    );

    always_comb
    begin
        if (s1_wi_reg == '0)
        begin
            acc_sum = {{(DIST_W+1-POP_W){1'b0}}, word_dist};
        end
        else
        begin
            acc_sum = {1'b0, running_reg} + {{(DIST_W+1-POP_W){1'b0}}, word_dist};
        end
        if (acc_sum > {1'b0, DIST_NONE})
        begin
            acc_sat = DIST_NONE;
        end
        else
        begin
            acc_sat = acc_sum[DIST_W-1:0];
        end
    end

    // ---------------------------------------------------------------
    // best and second-best tracking, strict less-than
    // ---------------------------------------------------------------
    track_t track_reg;
    track_t track_next;
    track_t track_clear;

    assign track_clear = '{best: DIST_NONE, second: DIST_NONE, best_idx: '0, have: 1'b0};

    always_comb
    begin
        running_next = running_reg;
        track_next   = track_reg;
        if (s1_do_cand)
        begin
            running_next = acc_sat;
            // judged on the last word of a candidate that is not skipped
            if ((s1_wi_reg == LAST_WORD) && !s1_skip_reg)
            begin
                if (acc_sat < track_reg.best)
                begin
                    track_next.second   = track_reg.best;
                    track_next.best     = acc_sat;
                    track_next.best_idx = s1_cidx_reg;
                end
                else if (acc_sat < track_reg.second)
                begin
                    track_next.second = acc_sat;
                end
                track_next.have = 1'b1;
            end
        end
        else if (s1_do_finish)
        begin
            // new query starts from a clean search
            running_next = '0;
            track_next   = track_clear;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            running_reg <= '0;
            track_reg   <= '{best: DIST_NONE, second: DIST_NONE, best_idx: '0, have: 1'b0};
        end
        else
        begin
            running_reg <= running_next;
            track_reg   <= track_next;
        end
    end

    // ---------------------------------------------------------------
    // decision and result register
    // ---------------------------------------------------------------
    result_t decision;
    result_t result_reg;

    hrtm_decide u_decide (
        .track     (track_reg),
        .threshold (threshold_reg),
        .ratio     (ratio_reg),
        .result    (decision)
    );

    always_comb
    begin
        if (s1_do_finish)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_do_finish)
        begin
            result_reg <= decision;
        end
    end

    assign out_valid       = out_valid_reg;
    assign match_found     = result_reg.match_found;
    assign best_index      = result_reg.best_index;
    assign best_distance   = result_reg.best_distance;
    assign second_distance = result_reg.second_distance;
    assign reject_reason   = result_reg.reject_reason;

endmodule

### hdl/hrtm_checker.sv
`include "hamming_ratio_test_matcher_assert.svh"

module hrtm_checker (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               out_valid,
    input  logic                               out_ready,
    input  logic                               match_found,
    input  logic [hrtm_pkg::IDX_W-1:0]         best_index,
    input  logic [hrtm_pkg::DIST_W-1:0]        best_distance,
    input  logic [hrtm_pkg::DIST_W-1:0]        second_distance,
    input  logic [1:0]                         reject_reason
);
    import hrtm_pkg::*;

    // a stalled result holds
    `HRTM_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(best_index) && $stable(best_distance) && $stable(reject_reason))

    // match flag agrees with the reason code
    `HRTM_ASSERT_NOW(a_match_reason, out_valid, match_found == (reject_reason == REASON_ACCEPT))

    // an empty search reports the cleared values
    `HRTM_ASSERT_NOW(a_no_cand, out_valid && (reject_reason == REASON_NO_CAND), (best_distance == DIST_NONE) && (second_distance == DIST_NONE) && (best_index == '0))

    // ordering of the two tracked distances
    `HRTM_ASSERT_NOW(a_order, out_valid, (best_distance <= second_distance) && (second_distance <= DIST_NONE))

endmodule

bind hamming_ratio_test_matcher hrtm_checker u_hrtm_checker (.*);

### dv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import hrtm_pkg::*;

    // the spare operation code, which the matcher must swallow silently
    localparam logic [1:0] OP_SPARE = 2'd3;

    // register map: one 32-bit slot per register
    localparam logic [ADDR_W-1:0] ADDR_THRESHOLD = {REG_THRESHOLD, 2'b00};
    localparam logic [ADDR_W-1:0] ADDR_RATIO     = {REG_RATIO, 2'b00};

    // values the registers should come out of reset with
    localparam logic [REG_W-1:0] DEFAULT_THRESHOLD = 9'd50;
    localparam logic [REG_W-1:0] DEFAULT_RATIO     = 9'd154;

    localparam int WORD_TARGET   = 1575;
    localparam int PHASE_WORDS   = 220;
    localparam int SETTLE_CYCLES = 4;       // margin after the last finish
    localparam int CYCLE_LIMIT   = 400000;

    logic clk = 1'b0;
    logic rst_n;

    logic                 in_valid;
    logic                 in_ready;
    logic [1:0]           operation;
    logic [WI_W-1:0]      word_index;
    logic [WORD_BITS-1:0] descriptor_word;
    logic [IDX_W-1:0]     candidate_index;
    logic                 candidate_skip;

    logic                 out_valid;
    logic                 out_ready;
    logic                 match_found;
    logic [IDX_W-1:0]     best_index;
    logic [DIST_W-1:0]    best_distance;
    logic [DIST_W-1:0]    second_distance;
    logic [1:0]           reject_reason;

    logic                 psel;
    logic                 penable;
    logic                 pwrite;
    logic [ADDR_W-1:0]    paddr;
    logic [31:0]          pwdata;
    logic [31:0]          prdata;
    logic                 pready;

    hamming_ratio_test_matcher u_dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .operation       (operation),
        .word_index      (word_index),
        .descriptor_word (descriptor_word),
        .candidate_index (candidate_index),
        .candidate_skip  (candidate_skip),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .match_found     (match_found),
        .best_index      (best_index),
        .best_distance   (best_distance),
        .second_distance (second_distance),
        .reject_reason   (reject_reason),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // matcher state as the testbench sees it
    // ------------------------------------------------------------------

    logic [WORD_BITS-1:0] query_words [NUM_WORDS];
    logic [DIST_W-1:0]    partial_dist;     // distance of the candidate in flight
    logic [DIST_W-1:0]    best_dist;
    logic [DIST_W-1:0]    second_dist;
    logic [IDX_W-1:0]     best_feature;
    logic                 seen_candidate;
    logic [REG_W-1:0]     threshold_reg;
    logic [REG_W-1:0]     ratio_reg;

    // decisions still owed by the matcher, oldest first
    result_t pending_decisions [$];

    // run bookkeeping
    int unsigned word_count = 0;
    int unsigned decision_count = 0;
    int unsigned outcome_hits [4];
    int unsigned setting_count = 0;
    int unsigned fail_count = 0;
    int unsigned cycle_count = 0;
    int unsigned stall_left = 0;
    bit          tx_gaps_on = 1'b0;
    bit          rx_stall_on = 1'b0;
    result_t     want;

    // back to an empty search, as after reset or a finish word
    task automatic clear_search();
        partial_dist   = '0;
        best_dist      = DIST_NONE;
        second_dist    = DIST_NONE;
        best_feature   = '0;
        seen_candidate = 1'b0;
    endtask

    // advance the tracked state by one accepted word, queueing a decision on finish
    task automatic track_word(input logic [1:0] op, input logic [WI_W-1:0] wi,
                              input logic [WORD_BITS-1:0] word,
                              input logic [IDX_W-1:0] feature, input logic skip);
        int unsigned acc;
        result_t     d;
        case (op)
            OP_LOAD:
                query_words[wi] = word;
            OP_CAND:
            begin
                // word 0 restarts the sum, later words add and saturate
                acc = $countones(word ^ query_words[wi]);
                if (wi != '0)
                    acc += partial_dist;
                if (acc > DESC_BITS)
                    acc = DESC_BITS;
                partial_dist = DIST_W'(acc);
                // only the last word of an unskipped candidate is judged
                if (wi == LAST_WORD && !skip)
                begin
                    if (acc < best_dist)
                    begin
                        second_dist  = best_dist;
                        best_dist    = DIST_W'(acc);
                        best_feature = feature;
                    end
                    else if (acc < second_dist)
                        second_dist = DIST_W'(acc);
                    seen_candidate = 1'b1;
                end
            end
            OP_FINISH:
            begin
                if (!seen_candidate)
                    d.reject_reason = REASON_NO_CAND;
                else if (threshold_reg > best_dist || threshold_reg == best_dist)
                begin
                    // ratio test in integer form: ratio/256 * second against best
                    if (int'(ratio_reg) * int'(second_dist) < 256 * int'(best_dist))
                        d.reject_reason = REASON_RATIO;
                    else
                        d.reject_reason = REASON_ACCEPT;
                end
                else
                    d.reject_reason = REASON_THRESH;
                d.match_found     = (d.reject_reason == REASON_ACCEPT);
                d.best_index      = best_feature;
                d.best_distance   = best_dist;
                d.second_distance = second_dist;
                pending_decisions.push_back(d);
                clear_search();
            end
            default:
                ;   // spare code: nothing changes
        endcase
    endtask

    // ------------------------------------------------------------------
    // random helpers
    // ------------------------------------------------------------------

    function automatic logic [WORD_BITS-1:0] any_word();
        return {$urandom, $urandom};
    endfunction

    function automatic logic [IDX_W-1:0] any_index();
        return IDX_W'($urandom);
    endfunction

    // mostly short, now and then long
    function automatic int unsigned idle_len();
        if ($urandom_range(0, 99) < 85)
            return $urandom_range(1, 3);
        return $urandom_range(4, 30);
    endfunction

    function automatic int unsigned sender_gap();
        if (!tx_gaps_on || $urandom_range(0, 99) < 55)
            return 0;
        return idle_len();
    endfunction

    // a mask with exactly the given number of distinct bits set
    function automatic logic [WORD_BITS-1:0] flip_mask(input int unsigned bits);
        logic [WORD_BITS-1:0] m;
        m = '0;
        if (bits >= WORD_BITS)
            return '1;
        while ($countones(m) < bits)
            m[$urandom_range(0, WORD_BITS - 1)] = 1'b1;
        return m;
    endfunction

    // candidate distances clustered around the current threshold
    function automatic int unsigned pick_distance();
        int unsigned r;
        int unsigned top;
        r   = $urandom_range(0, 99);
        top = threshold_reg + 40;
        if (top > DESC_BITS)
            top = DESC_BITS;
        if (r < 60)
            return $urandom_range(0, top);
        if (r < 85)
            return $urandom_range(0, 100);
        return $urandom_range(0, DESC_BITS);
    endfunction

    // ------------------------------------------------------------------
    // input channel
    // ------------------------------------------------------------------

    // present one word, hold it until taken, then fold it into the tracked state;
    // ready is looked at mid-cycle so nothing hangs on event order at the edge
    task automatic send_word(input logic [1:0] op, input logic [WI_W-1:0] wi,
                             input logic [WORD_BITS-1:0] word,
                             input logic [IDX_W-1:0] feature, input logic skip);
        int unsigned gap;
        gap = sender_gap();
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid        <= 1'b1;
        operation       <= op;
        word_index      <= wi;
        descriptor_word <= word;
        candidate_index <= feature;
        candidate_skip  <= skip;
        do
            @(negedge clk);
        while (!in_ready);
        @(posedge clk);
        track_word(op, wi, word, feature, skip);
        word_count++;
    endtask

    // a well-formed candidate at an exact distance from the query, spread over
    // the four words; index and skip only count on the last word, so the
    // earlier words carry junk there
    task automatic send_candidate(input int unsigned target_dist,
                                  input logic [IDX_W-1:0] feature, input logic skip);
        int unsigned left;
        int unsigned lo;
        int unsigned hi;
        int unsigned k;
        left = target_dist;
        for (int i = 0; i < NUM_WORDS; i++)
        begin
            hi = (left < WORD_BITS) ? left : WORD_BITS;
            lo = (left > WORD_BITS * (NUM_WORDS - 1 - i)) ?
                 left - WORD_BITS * (NUM_WORDS - 1 - i) : 0;
            k  = $urandom_range(hi, lo);
            left -= k;
            if (i == NUM_WORDS - 1)
                send_word(OP_CAND, WI_W'(i), query_words[i] ^ flip_mask(k), feature, skip);
            else
                send_word(OP_CAND, WI_W'(i), query_words[i] ^ flip_mask(k), any_index(),
                          1'($urandom));
        end
    endtask

    task automatic load_query();
        int unsigned r;
        logic [WORD_BITS-1:0] w;
        for (int i = 0; i < NUM_WORDS; i++)
        begin
            r = $urandom_range(0, 99);
            w = (r < 10) ? '0 : (r < 20) ? '1 : any_word();
            send_word(OP_LOAD, WI_W'(i), w, any_index(), 1'($urandom));
        end
    endtask

    // one search: maybe a new query, a handful of candidates with some
    // noise mixed in, then the finish word
    task automatic run_query();
        int unsigned n_items;
        int unsigned pick;
        if ($urandom_range(0, 99) < 30)
            load_query();
        n_items = $urandom_range(0, 5);
        repeat (n_items)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 80)
                send_candidate(pick_distance(), any_index(), $urandom_range(0, 99) < 15);
            else if (pick < 87)
            begin
                // unrelated content, distance somewhere near half
                for (int i = 0; i < NUM_WORDS; i++)
                    send_word(OP_CAND, WI_W'(i), any_word(), any_index(), 1'($urandom));
            end
            else if (pick < 94)
            begin
                // broken sequence: word indices out of order, may run the sum up to
                // saturation or judge a half-built candidate
                repeat ($urandom_range(1, 6))
                    send_word(OP_CAND, WI_W'($urandom), any_word(), any_index(),
                              1'($urandom));
            end
            else if (pick < 97)
                send_word(OP_SPARE, WI_W'($urandom), any_word(), any_index(), 1'($urandom));
            else
                send_word(OP_LOAD, WI_W'($urandom), any_word(), any_index(), 1'($urandom));
        end
        send_word(OP_FINISH, WI_W'($urandom), any_word(), any_index(), 1'($urandom));
    endtask

    // drop valid, let every owed decision drain, then let the pipe settle
    task automatic wait_idle();
        in_valid <= 1'b0;
        while (pending_decisions.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // ------------------------------------------------------------------
    // configuration port
    // ------------------------------------------------------------------

    task automatic reg_write(input logic [ADDR_W-1:0] addr, input logic [REG_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= 32'(value);
        @(posedge clk);
        penable <= 1'b1;
        do
            @(negedge clk);
        while (!pready);
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    task automatic reg_read_check(input logic [ADDR_W-1:0] addr, input logic [REG_W-1:0] value,
                                  input string reg_name);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= addr;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(negedge clk);
        while (!pready);
        if (prdata !== 32'(value))
        begin
            $error("%s: expected %0d, got %0d", reg_name, value, prdata);
            fail_count++;
        end
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    // new threshold and ratio, only ever with the matcher idle
    task automatic set_config(input logic [REG_W-1:0] thr, input logic [REG_W-1:0] ratio);
        wait_idle();
        reg_write(ADDR_THRESHOLD, thr);
        reg_write(ADDR_RATIO, ratio);
        threshold_reg = thr;
        ratio_reg     = ratio;
        reg_read_check(ADDR_THRESHOLD, thr, "distance_threshold");
        reg_read_check(ADDR_RATIO, ratio, "ratio_q8");
        setting_count++;
    endtask

    // ------------------------------------------------------------------
    // result channel: back-pressure and checking
    // ------------------------------------------------------------------

    // ready drops in bursts while stalling is on, and holds high otherwise
    initial
    begin
        out_ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (stall_left != 0)
            begin
                out_ready <= 1'b0;
                stall_left--;
            end
            else if (rx_stall_on && $urandom_range(0, 99) < 30)
            begin
                out_ready <= 1'b0;
                stall_left = idle_len() - 1;
            end
            else
                out_ready <= 1'b1;
        end
    end

    // a decision is taken at the next rising edge when valid and ready are both
    // high mid-cycle; compare it against the oldest one owed
    always @(negedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            decision_count++;
            if (pending_decisions.size() == 0)
            begin
                $error("decision with none owed: reason %0d, index %0d",
                       reject_reason, best_index);
                fail_count++;
            end
            else
            begin
                want = pending_decisions.pop_front();
                outcome_hits[want.reject_reason]++;
                if (match_found !== want.match_found)
                begin
                    $error("match_found: expected %0d, got %0d", want.match_found, match_found);
                    fail_count++;
                end
                if (best_index !== want.best_index)
                begin
                    $error("best_index: expected %0d, got %0d", want.best_index, best_index);
                    fail_count++;
                end
                if (best_distance !== want.best_distance)
                begin
                    $error("best_distance: expected %0d, got %0d",
                           want.best_distance, best_distance);
                    fail_count++;
                end
                if (second_distance !== want.second_distance)
                begin
                    $error("second_distance: expected %0d, got %0d",
                           want.second_distance, second_distance);
                    fail_count++;
                end
                if (reject_reason !== want.reject_reason)
                begin
                    $error("reject_reason: expected %0d, got %0d",
                           want.reject_reason, reject_reason);
                    fail_count++;
                end
            end
        end
    end

    // watchdog, far beyond the slowest legal run
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // registers must read back their reset values before anything is written
    task automatic test_register_reset();
        reg_read_check(ADDR_THRESHOLD, DEFAULT_THRESHOLD, "distance_threshold");
        reg_read_check(ADDR_RATIO, DEFAULT_RATIO, "ratio_q8");
    endtask

    // hand-built corner cases at the reset settings, no idling
    task automatic test_directed_cases();
        // finish before any candidate: no-candidate reject with the empty defaults
        send_word(OP_FINISH, '0, '0, '0, 1'b0);
        // query with all-zero and all-one words among the mix
        send_word(OP_LOAD, 2'd0, '0, 12'd4095, 1'b1);
        send_word(OP_LOAD, 2'd1, '1, 12'd0, 1'b0);
        send_word(OP_LOAD, 2'd2, 64'h5555_5555_5555_5555, 12'd2048, 1'b1);
        send_word(OP_LOAD, 2'd3, 64'hA5A5_0F0F_3C3C_C3C3, 12'd1, 1'b0);
        // fully inverted candidate: the largest distance, not better than empty
        send_candidate(DESC_BITS, 12'd0, 1'b0);
        // a further last word without a restart pushes the sum past full scale
        send_word(OP_CAND, LAST_WORD, ~query_words[LAST_WORD], 12'd100, 1'b0);
        // perfect copy but marked skip: must leave the tracking alone
        send_candidate(0, 12'd7, 1'b1);
        // two candidates at the same distance: strict less-than keeps the first
        send_candidate(10, 12'd4095, 1'b0);
        send_candidate(10, 12'd6, 1'b0);
        // spare operation code is swallowed
        send_word(OP_SPARE, 2'd3, '1, '1, 1'b1);
        // tied best and second fail the ratio test
        send_word(OP_FINISH, '0, '0, '0, 1'b0);
    endtask

    // the corner settings of both registers, then back to the defaults
    task automatic test_config_extremes();
        tx_gaps_on  = 1'b1;
        rx_stall_on = 1'b1;
        for (int s = 0; s < 5; s++)
        begin
            case (s)
                0: set_config(9'd0, 9'd0);
                1: set_config(9'd256, 9'd256);
                2: set_config(9'd0, 9'd256);
                3: set_config(9'd256, 9'd0);
                default: set_config(DEFAULT_THRESHOLD, DEFAULT_RATIO);
            endcase
            repeat (3) run_query();
        end
    endtask

    // bulk traffic in phases, each with its own settings and idling mix
    task automatic test_random_traffic();
        int unsigned phase_end;
        int unsigned r;
        while (word_count < WORD_TARGET)
        begin
            r = $urandom_range(0, 99);
            if (r < 15)
                set_config($urandom_range(0, 1) ? 9'd256 : 9'd0,
                           $urandom_range(0, 1) ? 9'd256 : 9'd0);
            else if (r < 30)
                set_config(9'($urandom_range(0, 256)), 9'($urandom_range(0, 256)));
            else
                set_config(9'($urandom_range(10, 120)), 9'($urandom_range(100, 256)));
            // some phases run flat out on one side or both
            tx_gaps_on  = $urandom_range(0, 99) < 75;
            rx_stall_on = $urandom_range(0, 99) < 75;
            phase_end   = word_count + PHASE_WORDS;
            while (word_count < phase_end && word_count < WORD_TARGET)
                run_query();
        end
    endtask

    initial
    begin
        rst_n           <= 1'b0;
        in_valid        <= 1'b0;
        operation       <= OP_LOAD;
        word_index      <= '0;
        descriptor_word <= '0;
        candidate_index <= '0;
        candidate_skip  <= 1'b0;
        psel            <= 1'b0;
        penable         <= 1'b0;
        pwrite          <= 1'b0;
        paddr           <= '0;
        pwdata          <= '0;
        threshold_reg   = DEFAULT_THRESHOLD;
        ratio_reg       = DEFAULT_RATIO;
        clear_search();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_register_reset();
        test_directed_cases();
        test_config_extremes();
        test_random_traffic();

        // drain and let the last finish settle
        wait_idle();

        $display("run covered %0d words and %0d decisions over %0d register settings",
                 word_count, decision_count, setting_count);
        $display("outcomes: %0d accepted, %0d over threshold, %0d ratio, %0d empty",
                 outcome_hits[REASON_ACCEPT], outcome_hits[REASON_THRESH],
                 outcome_hits[REASON_RATIO], outcome_hits[REASON_NO_CAND]);
        if (fail_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

### sim.f
+incdir+hdl
hdl/hrtm_pkg.sv
hdl/hrtm_popcount.sv
hdl/hrtm_decide.sv
hdl/hamming_ratio_test_matcher.sv
hdl/hrtm_checker.sv
dv/tb_top.sv
